// ===== hdl/ardp_pkg.sv =====
package ardp_pkg;

  typedef enum logic [3:0] {
    OP_AND = 4'd0,
    OP_EOR = 4'd1,
    OP_SUB = 4'd2,
    OP_RSB = 4'd3,
    OP_ADD = 4'd4,
    OP_ADC = 4'd5,
    OP_SBC = 4'd6,
    OP_RSC = 4'd7,
    OP_TST = 4'd8,
    OP_TEQ = 4'd9,
    OP_CMP = 4'd10,
    OP_CMN = 4'd11,
    OP_ORR = 4'd12,
    OP_MOV = 4'd13,
    OP_BIC = 4'd14,
    OP_MVN = 4'd15
  } alu_op_t;

  typedef enum logic [1:0] {
    SH_LSL = 2'd0,
    SH_LSR = 2'd1,
    SH_ASR = 2'd2,
    SH_ROR = 2'd3
  } shift_type_t;

  localparam logic [1:0] KIND_ROT_IMM   = 2'd0;
  localparam logic [1:0] KIND_SHIFT_IMM = 2'd1;

  typedef struct packed {
    logic [3:0]  alu_op;
    logic [1:0]  kind;
    logic [1:0]  shift_type;
    logic [4:0]  shift_amount_imm;
    logic [7:0]  shift_amount_reg;
    logic [31:0] rm_word;
    logic [31:0] rn_word;
    logic [7:0]  immed_8;
    logic [3:0]  rot_field;
    logic        carry_in;
    logic        set_flags;
    logic [3:0]  dest_reg;
  } ardp_in_t;

  typedef struct packed {
    logic [31:0] result;
    logic [3:0]  dest_index;
    logic        write_dest;
    logic        update_flags;
    logic        flag_n;
    logic        flag_z;
    logic        flag_c;
    logic        flag_v;
    logic        v_changed;
  } ardp_out_t;

  // shifter stage -> ALU stage
  typedef struct packed {
    alu_op_t     alu_op;
    logic [31:0] shifter_op;
    logic        shifter_co;
    logic [31:0] rn_word;
    logic        carry_in;
    logic        set_flags;
    logic [3:0]  dest_reg;
  } ardp_shf_t;

  // ALU stage -> flag stage
  typedef struct packed {
    logic [31:0] result;
    logic [3:0]  dest_index;
    logic        write_dest;
    logic        update_flags;
    logic        flag_c;
    logic        flag_v;
    logic        v_changed;
  } ardp_exe_t;

  function automatic logic [31:0] ror32(input logic [31:0] v, input logic [4:0] n);
    logic [63:0] d;
    d = {v, v} >> n;
    return d[31:0];
  endfunction

endpackage

// ===== hdl/ardp_shifter.sv =====
module ardp_shifter
  import ardp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ardp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ardp_shf_t out_data
);

  logic             valid_r, valid_nxt;
  ardp_shf_t        data_r, data_nxt;
  logic [7:0]       amount;
  logic             rrx;
  shift_type_t      stype;
  logic [32:0]      wide;
  logic signed [32:0] ext;
  logic [31:0]      sop;
  logic             sco;

  assign stype = shift_type_t'(in_data.shift_type);

  always_comb begin
    amount = 8'd0;
    rrx    = 1'b0;
    wide   = '0;
    ext    = $signed({in_data.rm_word, 1'b0});
    sop    = in_data.rm_word;
    sco    = in_data.carry_in;
    if (in_data.kind == KIND_ROT_IMM) begin
      sop = ror32({24'd0, in_data.immed_8}, {in_data.rot_field, 1'b0});
      sco = (in_data.rot_field == 4'd0) ? in_data.carry_in : sop[31];
    end else begin
      if (in_data.kind == KIND_SHIFT_IMM) begin
        amount = {3'd0, in_data.shift_amount_imm};
        // immediate LSR/ASR by zero mean 32, ROR by zero is RRX
        if (in_data.shift_amount_imm == 5'd0) begin
          if (stype == SH_LSR || stype == SH_ASR) begin
            amount = 8'd32;
          end
          if (stype == SH_ROR) begin
            rrx = 1'b1;
          end
        end
      end else begin
        amount = in_data.shift_amount_reg;
      end
      if (rrx) begin
        sop = {in_data.carry_in, in_data.rm_word[31:1]};
        sco = in_data.rm_word[0];
      end else if (amount != 8'd0) begin
        case (stype)
          SH_LSL: begin
            wide = {1'b0, in_data.rm_word} << amount;
            sop  = wide[31:0];
            sco  = wide[32];
          end
          SH_LSR: begin
            wide = {in_data.rm_word, 1'b0} >> amount;
            sop  = wide[32:1];
            sco  = wide[0];
          end
          SH_ASR: begin
            wide = ext >>> amount;
            sop  = wide[32:1];
            sco  = wide[0];
          end
          default: begin
            sop = ror32(in_data.rm_word, amount[4:0]);
            sco = sop[31];
          end
        endcase
      end
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.alu_op     = alu_op_t'(in_data.alu_op);
    data_nxt.shifter_op = sop;
    data_nxt.shifter_co = sco;
    data_nxt.rn_word    = in_data.rn_word;
    data_nxt.carry_in   = in_data.carry_in;
    data_nxt.set_flags  = in_data.set_flags;
    data_nxt.dest_reg   = in_data.dest_reg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/ardp_alu.sv =====
module ardp_alu
  import ardp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ardp_shf_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ardp_exe_t out_data
);

  logic        valid_r, valid_nxt;
  ardp_exe_t   data_r, data_nxt;
  logic [31:0] x, y, logic_res;
  logic        ci, arith, is_test, upd;
  logic [32:0] sum;

  always_comb begin
    x         = in_data.rn_word;
    y         = in_data.shifter_op;
    ci        = 1'b0;
    arith     = 1'b1;
    logic_res = '0;
    case (in_data.alu_op)
      OP_AND, OP_TST: begin
        arith     = 1'b0;
        logic_res = in_data.rn_word & in_data.shifter_op;
      end
      OP_EOR, OP_TEQ: begin
        arith     = 1'b0;
        logic_res = in_data.rn_word ^ in_data.shifter_op;
      end
      OP_ORR: begin
        arith     = 1'b0;
        logic_res = in_data.rn_word | in_data.shifter_op;
      end
      OP_MOV: begin
        arith     = 1'b0;
        logic_res = in_data.shifter_op;
      end
      OP_BIC: begin
        arith     = 1'b0;
        logic_res = in_data.rn_word & ~in_data.shifter_op;
      end
      OP_MVN: begin
        arith     = 1'b0;
        logic_res = ~in_data.shifter_op;
      end
      OP_SUB, OP_CMP: begin
        y  = ~in_data.shifter_op;
        ci = 1'b1;
      end
      OP_RSB: begin
        x  = in_data.shifter_op;
        y  = ~in_data.rn_word;
        ci = 1'b1;
      end
      OP_ADD, OP_CMN: begin
        ci = 1'b0;
      end
      OP_ADC: begin
        ci = in_data.carry_in;
      end
      OP_SBC: begin
        y  = ~in_data.shifter_op;
        ci = in_data.carry_in;
      end
      default: begin
        x  = in_data.shifter_op;
        y  = ~in_data.rn_word;
        ci = in_data.carry_in;
      end
    endcase
  end

  assign sum     = {1'b0, x} + {1'b0, y} + {32'd0, ci};
  assign is_test = (in_data.alu_op == OP_TST) || (in_data.alu_op == OP_TEQ) ||
                   (in_data.alu_op == OP_CMP) || (in_data.alu_op == OP_CMN);
  assign upd     = in_data.set_flags || is_test;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.result       = arith ? sum[31:0] : logic_res;
    data_nxt.dest_index   = in_data.dest_reg;
    data_nxt.write_dest   = !is_test;
    data_nxt.update_flags = upd;
    data_nxt.flag_c       = arith ? sum[32] : in_data.shifter_co;
    data_nxt.flag_v       = arith && ((x[31] ^ sum[31]) & (y[31] ^ sum[31]));
    data_nxt.v_changed    = arith && upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/ardp_flags.sv =====
module ardp_flags
  import ardp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ardp_exe_t in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ardp_out_t out_data
);

  logic      valid_r, valid_nxt;
  ardp_out_t data_r, data_nxt;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
    data_nxt.result       = in_data.result;
    data_nxt.dest_index   = in_data.dest_index;
    data_nxt.write_dest   = in_data.write_dest;
    data_nxt.update_flags = in_data.update_flags;
    data_nxt.flag_n       = in_data.result[31];
    data_nxt.flag_z       = (in_data.result == 32'd0);
    data_nxt.flag_c       = in_data.flag_c;
    data_nxt.flag_v       = in_data.flag_v;
    data_nxt.v_changed    = in_data.v_changed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== hdl/arm_data_processing_alu.sv =====
// Port group  Handshake             Payload
// in_         in_valid / in_ready   in_data  (ardp_in_t)
// out_        out_valid / out_ready out_data (ardp_out_t)
//
// Three register stages: barrel shifter, adder/logic unit, flag and output register.
// One item enters per cycle while no stage is stalled; an accepted item is registered in
// the shifter, ALU and flag registers in turn; out_valid rises when it reaches the last.
// rst_n (synchronous) clears the stage valid bits only.
// Each stage holds its item while the next one is full and stalled, so bubbles collapse
// and in_ready stays high whenever out_ready is high.
module arm_data_processing_alu
  import ardp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  ardp_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output ardp_out_t out_data
);

  logic      shf_valid, shf_ready;
  ardp_shf_t shf_data;
  logic      exe_valid, exe_ready;
  ardp_exe_t exe_data;

  ardp_shifter u_shifter (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (shf_valid),
    .out_ready (shf_ready),
    .out_data  (shf_data)
  );

  ardp_alu u_alu (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (shf_valid),
    .in_ready  (shf_ready),
    .in_data   (shf_data),
    .out_valid (exe_valid),
    .out_ready (exe_ready),
    .out_data  (exe_data)
  );

  ardp_flags u_flags (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (exe_valid),
    .in_ready  (exe_ready),
    .in_data   (exe_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  a_test_updates: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_dest |-> out_data.update_flags)
    else $error("compare/test item without flag update");

  a_v_needs_upd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.v_changed |-> out_data.update_flags)
    else $error("V changed without flag update");

  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.flag_z == (out_data.result == 32'd0)))
    else $error("Z flag does not match result");

  a_empty_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !shf_valid && !exe_valid && !out_valid |=>
      shf_valid)
    else $error("accepted item lost in shifter stage");

endmodule
